@@ hw/rtl/y2n_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the YUY2 to NV12 converter.
// No dependencies; used by the front end, the job queue, the emitter and the top level.
package y2n_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int JOB_QUEUE_DEPTH = 2;

    localparam int ADDR_W   = 26;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 14;
    localparam int FW_W     = 12;
    localparam int FH_W     = 13;
    localparam int STRIDE_W = 14;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PAIRS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE      = 2'd2;

    localparam logic [FW_W-1:0]     RST_WIDTH_PAIRS = 12'd320;
    localparam logic [FH_W-1:0]     RST_HEIGHT      = 13'd480;
    localparam logic [STRIDE_W-1:0] RST_STRIDE      = 14'd640;

    // Output plane codes.
    localparam logic PLANE_LUMA   = 1'b0;
    localparam logic PLANE_CHROMA = 1'b1;

    // One classified pair, handed from the front end to the emitter.
    typedef struct packed {
        logic [ADDR_W-1:0] luma_addr;
        logic [ADDR_W-1:0] chroma_addr;
        logic [7:0]        y0;
        logic [7:0]        u;
        logic [7:0]        y1;
        logic [7:0]        v;
        logic              even_row;
        logic              last_pair;
    } job_t;

endpackage

@@ hw/rtl/y2n_front.sv @@
`timescale 1ns / 1ps
// Front end: configuration registers, frame position tracking and address generation.
// Depends on y2n_pkg.
module y2n_front
    import y2n_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_accept,
    input  logic                  in_frame_start,
    input  logic [31:0]           in_pixels,
    output job_t                  job
);

    localparam int LIM_W  = (MAX_WIDTH / 2 < 1) ? 1 : MAX_WIDTH / 2;
    localparam int COL_W  = (LIM_W > 1) ? $clog2(LIM_W) : 1;
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CMP_W  = 14;

    logic [FW_W-1:0]     width_pairs_reg;
    logic [FH_W-1:0]     height_reg;
    logic [STRIDE_W-1:0] stride_reg;

    logic              pend_reg;    // position restarts before the next pair
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] luma_base_reg;
    logic [ADDR_W-1:0] chroma_base_reg;

    logic [CMP_W-1:0]    eff_w;
    logic [CMP_W-1:0]    eff_h;
    logic [2*CMP_W-1:0]  plane_size;
    logic                restart;
    logic [COL_W-1:0]    col_e;
    logic [ROW_W-1:0]    row_e;
    logic [ADDR_W-1:0]   luma_e;
    logic [ADDR_W-1:0]   chroma_e;
    logic [ADDR_W-1:0]   xoff;
    logic [ADDR_W-1:0]   stride_ext;
    logic                col_end;
    logic                row_last;
    logic                cfg_hit;

    always_comb begin
        eff_w = CMP_W'(width_pairs_reg);
        if (eff_w == '0) begin
            eff_w = CMP_W'(1);
        end
        if (eff_w > CMP_W'(LIM_W)) begin
            eff_w = CMP_W'(LIM_W);
        end
        eff_h = CMP_W'(height_reg);
        if (eff_h < CMP_W'(2)) begin
            eff_h = CMP_W'(2);
        end
        if (eff_h > CMP_W'(MAX_HEIGHT)) begin
            eff_h = CMP_W'(MAX_HEIGHT);
        end
        plane_size = (2*CMP_W)'(stride_reg) * (2*CMP_W)'(eff_h);

        restart  = in_frame_start | pend_reg;
        col_e    = restart ? '0 : col_reg;
        row_e    = restart ? '0 : row_reg;
        luma_e   = restart ? '0 : luma_base_reg;
        chroma_e = restart ? plane_size[ADDR_W-1:0] : chroma_base_reg;
        xoff       = ADDR_W'({col_e, 1'b0});
        stride_ext = ADDR_W'(stride_reg);

        col_end  = (CMP_W'(col_e) + CMP_W'(1)) >= eff_w;
        row_last = (CMP_W'(row_e) + CMP_W'(1)) >= eff_h;

        job.luma_addr   = luma_e + xoff;
        job.chroma_addr = chroma_e + xoff;
        job.y0          = in_pixels[7:0];
        job.u           = in_pixels[15:8];
        job.y1          = in_pixels[23:16];
        job.v           = in_pixels[31:24];
        job.even_row    = ~row_e[0];
        job.last_pair   = col_end & row_last;

        case (cfg_index)
            REG_WIDTH_PAIRS: cfg_hit = 1'b1;
            REG_HEIGHT:      cfg_hit = 1'b1;
            REG_STRIDE:      cfg_hit = 1'b1;
            default:         cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_pairs_reg <= RST_WIDTH_PAIRS;
            height_reg      <= RST_HEIGHT;
            stride_reg      <= RST_STRIDE;
            pend_reg        <= 1'b1;
            col_reg         <= '0;
            row_reg         <= '0;
            luma_base_reg   <= '0;
        end else if (cfg_valid && cfg_hit) begin
            case (cfg_index)
                REG_WIDTH_PAIRS: width_pairs_reg <= cfg_data[FW_W-1:0];
                REG_HEIGHT:      height_reg      <= cfg_data[FH_W-1:0];
                REG_STRIDE:      stride_reg      <= cfg_data[STRIDE_W-1:0];
                default:         ;
            endcase
            pend_reg      <= 1'b1;
            col_reg       <= '0;
            row_reg       <= '0;
            luma_base_reg <= '0;
        end else if (in_accept) begin
            if (job.last_pair) begin
                pend_reg      <= 1'b1;
                col_reg       <= '0;
                row_reg       <= '0;
                luma_base_reg <= '0;
            end else begin
                pend_reg <= 1'b0;
                if (col_end) begin
                    col_reg         <= '0;
                    row_reg         <= row_e + ROW_W'(1);
                    luma_base_reg   <= luma_e + stride_ext;
                    chroma_base_reg <= job.even_row ? chroma_e : chroma_e + stride_ext;
                end else begin
                    col_reg         <= col_e + COL_W'(1);
                    row_reg         <= row_e;
                    luma_base_reg   <= luma_e;
                    chroma_base_reg <= chroma_e;
                end
            end
        end
    end

endmodule

@@ hw/rtl/y2n_queue.sv @@
`timescale 1ns / 1ps
// Short job queue between the front end and the emitter.
// Depends on y2n_pkg for the job type.
module y2n_queue
    import y2n_pkg::*;
#(
    parameter int DEPTH = JOB_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ hw/rtl/y2n_emit.sv @@
`timescale 1ns / 1ps
// Emitter: turns each queued job into a luma word and, on even rows, a chroma word.
// Depends on y2n_pkg.
module y2n_emit
    import y2n_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser
);

    typedef enum logic {PH_LUMA, PH_CHROMA} phase_t;

    phase_t            phase_reg;
    logic              valid_reg;
    logic              plane_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        even_reg;
    logic [7:0]        odd_reg;
    logic              item_last_reg;
    logic              frame_end_reg;
    logic              load;

    assign load    = ~valid_reg | m_axis_tready;
    assign job_pop = load & job_valid & ((phase_reg == PH_CHROMA) | ~job.even_row);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LUMA;
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= job_valid;
            if (job_valid) begin
                frame_end_reg <= job.last_pair;
                case (phase_reg)
                    PH_CHROMA: begin
                        plane_reg     <= PLANE_CHROMA;
                        addr_reg      <= job.chroma_addr;
                        even_reg      <= job.u;
                        odd_reg       <= job.v;
                        item_last_reg <= 1'b1;
                        phase_reg     <= PH_LUMA;
                    end
                    default: begin
                        plane_reg     <= PLANE_LUMA;
                        addr_reg      <= job.luma_addr;
                        even_reg      <= job.y0;
                        odd_reg       <= job.y1;
                        item_last_reg <= ~job.even_row;
                        phase_reg     <= job.even_row ? PH_CHROMA : PH_LUMA;
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {6'b0, odd_reg, even_reg, addr_reg};
    assign m_axis_tlast  = item_last_reg;
    assign m_axis_tuser  = {frame_end_reg, plane_reg};

endmodule

@@ hw/rtl/yuy2_to_nv12_converter.sv @@
`timescale 1ns / 1ps
// Top level of the YUY2 to NV12 converter: front end, job queue and emitter.
// Depends on y2n_pkg, y2n_front, y2n_queue and y2n_emit.
//
//  Channel   | Direction | Word contents
//  ----------+-----------+------------------------------------------------------------
//  s_axis    | in        | one YUY2 pair (Y0 U Y1 V), tuser = start of frame
//  m_axis    | out       | one NV12 byte-pair write, tlast = last word of its pair
//  cfg       | in        | register write: 0 width in pairs, 1 height, 2 row stride
//
// Each accepted pair yields one output word on odd rows and two (luma, then chroma)
// on even rows; m_axis carries a single output word per cycle while m_axis_tready
// is high, so a pair on an even row takes longer to drain than one on an odd row.
// An input word is taken in every cycle in which the two-entry job queue has room,
// so the front end keeps working while the emitter waits on m_axis_tready.
// Reset is synchronous and active low; it loads 320 pairs, 480 rows, stride 640 and
// puts the position at the start of a frame. A write to register 0, 1 or 2 does the same
// with the new values. Configuration is always accepted (cfg_ready is tied high).
module yuy2_to_nv12_converter
    import y2n_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input pairs.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // luma_first, chroma_blue, luma_second,
                                                 // chroma_red (8 bits each, from bit 0)
    input  logic                  s_axis_tuser,  // frame_start
    // Output writes.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,  // byte_address[25:0], byte_even[33:26],
                                                 // byte_odd[41:34], zero fill above
    output logic                  m_axis_tlast,  // item_last
    output logic [1:0]            m_axis_tuser,  // plane[0], frame_end[1]
    // Register writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    job_t front_job;
    job_t head_job;
    logic queue_full;
    logic head_valid;
    logic head_pop;
    logic in_accept;

    // A pair is taken whenever the queue can hold its job.
    assign s_axis_tready = ~queue_full;
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign cfg_ready     = 1'b1;

    y2n_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_accept      (in_accept),
        .in_frame_start (s_axis_tuser),
        .in_pixels      (s_axis_tdata),
        .job            (front_job)
    );

    y2n_queue #(
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (in_accept),
        .push_job   (front_job),
        .full       (queue_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // The emitter holds the output word in a register, so a stalled m_axis
    // never blocks the front end until the queue fills.
    y2n_emit u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (head_valid),
        .job           (head_job),
        .job_pop       (head_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the YUY2 to NV12 converter. It streams YUY2 pairs, predicts
// every luma and chroma write of the NV12 frame, and compares them word by word.
// Depends on y2n_pkg and the yuy2_to_nv12_converter RTL.
module testbench;
    import y2n_pkg::*;

    // The receiver's one long stall. The sender keeps offering words during it, so the
    // two-entry job queue fills up and s_axis_tready drops.
    localparam int LONG_HOLD   = 300;
    // Cycles without any accepted word before the run is declared hung.
    localparam int IDLE_LIMIT  = 2000;
    // Quiet cycles after the last expected write, to catch stray output words.
    localparam int TAIL_CYCLES = 20;
    // Only the first few mismatches are printed; all are counted.
    localparam int MAX_PRINTED = 20;

    // The register list ends at index 2; a write to index 3 must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] u;
        logic [7:0] y1;
        logic [7:0] v;
        logic       sof;
    } yuy2_pair_t;

    typedef struct packed {
        logic              plane;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        byte_even;
        logic [7:0]        byte_odd;
        logic              item_last;
        logic              frame_end;
    } plane_write_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [47:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic [1:0]            m_axis_tuser;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    yuy2_to_nv12_converter u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Stimulus waiting to be sent and writes waiting to be seen.
    yuy2_pair_t   pending_pairs[$];
    plane_write_t expected_writes[$];
    yuy2_pair_t   next_pair;

    int pairs_queued   = 0;
    int pairs_accepted = 0;
    int writes_checked = 0;
    int reg_writes     = 0;
    int formats_run    = 0;
    int error_count    = 0;
    int send_gap       = 0;
    int ready_wait     = 0;
    int idle_cycles    = 0;
    bit no_gaps        = 1'b0;
    bit hold_arm       = 1'b0;
    bit hold_done      = 1'b0;

    // Predictor copy of the registers and of the frame position.
    logic [FW_W-1:0]     width_pairs_reg;
    logic [FH_W-1:0]     height_reg;
    logic [STRIDE_W-1:0] stride_reg;
    int                  column_pair;
    int                  row_index;
    logic [ADDR_W-1:0]   luma_base;
    logic [ADDR_W-1:0]   chroma_base;

    // A width of zero acts as one pair; anything above half the maximum width saturates.
    function automatic int active_width();
        int w = width_pairs_reg;
        if (w < 1) w = 1;
        if (w > DEF_MAX_WIDTH / 2) w = DEF_MAX_WIDTH / 2;
        return w;
    endfunction

    // Heights below two act as two, heights above the maximum saturate, odd ones stand.
    function automatic int active_height();
        int h = height_reg;
        if (h < 2) h = 2;
        if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
        return h;
    endfunction

    // The chroma plane starts right after stride times height luma bytes, modulo 2^26.
    function automatic void restart_position();
        column_pair = 0;
        row_index   = 0;
        luma_base   = '0;
        chroma_base = ADDR_W'(int'(stride_reg) * active_height());
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_WIDTH_PAIRS: begin
                width_pairs_reg = value[FW_W-1:0];
                restart_position();
            end
            REG_HEIGHT: begin
                height_reg = value[FH_W-1:0];
                restart_position();
            end
            REG_STRIDE: begin
                stride_reg = value[STRIDE_W-1:0];
                restart_position();
            end
            default: ;
        endcase
    endfunction

    // Places one pair in the frame: a luma write always, a chroma write on even rows only.
    function automatic void predict_writes(input yuy2_pair_t pair);
        int                w;
        int                h;
        logic [ADDR_W-1:0] xoff;
        bit                even_row;
        bit                last_pair;
        plane_write_t      wr;
        w = active_width();
        h = active_height();
        if (pair.sof) restart_position();
        xoff      = ADDR_W'(column_pair * 2);
        even_row  = (row_index % 2) == 0;
        last_pair = (column_pair + 1 >= w) && (row_index + 1 >= h);

        wr.plane     = PLANE_LUMA;
        wr.addr      = luma_base + xoff;
        wr.byte_even = pair.y0;
        wr.byte_odd  = pair.y1;
        wr.item_last = !even_row;
        wr.frame_end = last_pair;
        expected_writes.insert(expected_writes.size(), wr);

        if (even_row) begin
            wr.plane     = PLANE_CHROMA;
            wr.addr      = chroma_base + xoff;
            wr.byte_even = pair.u;
            wr.byte_odd  = pair.v;
            wr.item_last = 1'b1;
            expected_writes.insert(expected_writes.size(), wr);
        end

        if (last_pair) begin
            restart_position();
        end else begin
            column_pair++;
            if (column_pair >= w) begin
                column_pair = 0;
                // One chroma row covers two luma rows, so it advances after odd rows.
                if (!even_row) chroma_base = chroma_base + ADDR_W'(stride_reg);
                row_index++;
                luma_base = luma_base + ADDR_W'(stride_reg);
            end
        end
    endfunction

    task automatic report_failure(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_write(input plane_write_t want);
        plane_write_t got;
        got.plane     = m_axis_tuser[0];
        got.frame_end = m_axis_tuser[1];
        got.addr      = m_axis_tdata[25:0];
        got.byte_even = m_axis_tdata[33:26];
        got.byte_odd  = m_axis_tdata[41:34];
        got.item_last = m_axis_tlast;
        if (got.plane !== want.plane)
            report_failure($sformatf("write %0d plane: expected %0d, got %0d",
                                     writes_checked, want.plane, got.plane));
        if (got.addr !== want.addr)
            report_failure($sformatf("write %0d address: expected 0x%07h, got 0x%07h",
                                     writes_checked, want.addr, got.addr));
        if (got.byte_even !== want.byte_even)
            report_failure($sformatf("write %0d even byte: expected 0x%02h, got 0x%02h",
                                     writes_checked, want.byte_even, got.byte_even));
        if (got.byte_odd !== want.byte_odd)
            report_failure($sformatf("write %0d odd byte: expected 0x%02h, got 0x%02h",
                                     writes_checked, want.byte_odd, got.byte_odd));
        if (got.item_last !== want.item_last)
            report_failure($sformatf("write %0d tlast: expected %0d, got %0d",
                                     writes_checked, want.item_last, got.item_last));
        if (got.frame_end !== want.frame_end)
            report_failure($sformatf("write %0d frame end: expected %0d, got %0d",
                                     writes_checked, want.frame_end, got.frame_end));
    endtask

    // Monitor. All three channels are sampled at the rising edge, before any
    // nonblocking update of that edge lands, so the order of processes does not matter.
    // Register writes only happen while the block is idle, so they never share an
    // edge with a pair that depends on them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            width_pairs_reg = RST_WIDTH_PAIRS;
            height_reg      = RST_HEIGHT;
            stride_reg      = RST_STRIDE;
            restart_position();
        end else begin
            if (cfg_valid && cfg_ready) begin
                apply_register(cfg_index, cfg_data);
                reg_writes++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_writes({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                                s_axis_tdata[31:24], s_axis_tuser});
                pairs_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_writes.size() == 0)
                    report_failure($sformatf("unexpected output word 0x%012h", m_axis_tdata));
                else
                    check_write(expected_writes.pop_front());
                writes_checked++;
            end
        end
    end

    // Sender. A new word is loaded once the current one is taken, after a random gap
    // drawn for each word, or with no gap when no_gaps is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap != 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
                next_pair      = pending_pairs.pop_front();
                s_axis_tdata  <= {next_pair.v, next_pair.y1, next_pair.u, next_pair.y0};
                s_axis_tuser  <= next_pair.sof;
                s_axis_tvalid <= 1'b1;
                send_gap      <= no_gaps ? 0 : $urandom_range(0, 4);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver. After each accepted word it may drop tready for a random wait, never when
    // no_gaps is set; once armed it holds off for one long stretch counted here.
    always @(posedge aclk) begin
        int draw;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            ready_wait    <= 0;
            hold_done     <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            hold_done     <= 1'b1;
            ready_wait    <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (ready_wait != 0) begin
            ready_wait    <= ready_wait - 1;
            m_axis_tready <= (ready_wait == 1);
        end else if (m_axis_tvalid && m_axis_tready) begin
            draw = no_gaps ? 0 : $urandom_range(0, 4);
            ready_wait    <= draw;
            m_axis_tready <= (draw == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: a run in which nothing moves for too long is hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: nothing accepted for %0d cycles, %0d writes still expected",
                     IDLE_LIMIT, expected_writes.size());
            $display("** yuy2_to_nv12_converter: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Starts one register write; the caller lowers cfg_valid after its last write, so
    // back-to-back writes keep valid high without a glitch.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_format(input logic [CFG_DATA_W-1:0] width_pairs,
                                  input logic [CFG_DATA_W-1:0] height,
                                  input logic [CFG_DATA_W-1:0] stride);
        write_register(REG_WIDTH_PAIRS, width_pairs);
        write_register(REG_HEIGHT, height);
        write_register(REG_STRIDE, stride);
        cfg_valid <= 1'b0;
        formats_run++;
    endtask

    task automatic queue_pair(input logic [7:0] y0, input logic [7:0] u,
                              input logic [7:0] y1, input logic [7:0] v, input logic sof);
        pending_pairs.insert(pending_pairs.size(), {y0, u, y1, v, sof});
        pairs_queued++;
    endtask

    // Random bytes; roughly one pair in sixteen restarts the frame.
    task automatic queue_pairs(input int count);
        repeat (count)
            queue_pair(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       $urandom_range(0, 15) == 0);
    endtask

    // Idle means every queued pair taken and every predicted write seen.
    task automatic wait_for_drain();
        while (pairs_accepted != pairs_queued || expected_writes.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] width_pairs,
                             input logic [CFG_DATA_W-1:0] height,
                             input logic [CFG_DATA_W-1:0] stride,
                             input int count, input bit gapless);
        program_format(width_pairs, height, stride);
        no_gaps <= gapless;
        queue_pairs(count);
        wait_for_drain();
    endtask

    initial begin
        int mark;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset format: 320 pairs by 480 rows, stride 640, so chroma starts at 307200.
        queue_pair(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
        queue_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        queue_pair(8'hA5, 8'h5A, 8'h0F, 8'hF0, 1'b0);
        wait_for_drain();

        // A write past the register list must leave the position alone.
        write_register(REG_SPARE, '1);
        cfg_valid <= 1'b0;
        queue_pair(8'h01, 8'h80, 8'hFE, 8'h7F, 1'b0);
        queue_pair(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b0);
        wait_for_drain();

        // A frame of two pairs by two rows: even and odd rows, the frame end and its
        // wrap, then a frame start in the middle of a frame.
        program_format(14'd2, 14'd2, 14'd4);
        queue_pair(8'h10, 8'h20, 8'h30, 8'h40, 1'b0);
        queue_pair(8'h11, 8'h21, 8'h31, 8'h41, 1'b0);
        queue_pair(8'h12, 8'h22, 8'h32, 8'h42, 1'b0);
        queue_pair(8'h13, 8'h23, 8'h33, 8'h43, 1'b0);
        queue_pair(8'h14, 8'h24, 8'h34, 8'h44, 1'b0);
        queue_pair(8'h15, 8'h25, 8'h35, 8'h45, 1'b0);
        queue_pair(8'h16, 8'h26, 8'h36, 8'h46, 1'b1);
        queue_pair(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
        wait_for_drain();

        // Zero width acts as one pair, a height of one acts as two, zero stride is kept.
        program_format(14'd0, 14'd1, 14'd0);
        queue_pair(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
        queue_pair(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
        queue_pair(8'h81, 8'h42, 8'h24, 8'h18, 1'b0);
        wait_for_drain();

        // All-ones register data: width and height saturate, stride at its top.
        program_format('1, '1, '1);
        queue_pair(8'hC3, 8'h3C, 8'h96, 8'h69, 1'b0);
        queue_pair(8'h7E, 8'hE7, 8'hBD, 8'hDB, 1'b0);
        queue_pair(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1);
        wait_for_drain();

        // Random part. Small frames wrap often; a one-pair width with the top stride and
        // height walks the chroma base past 2^26 within a few rows.
        run_phase(14'd0, 14'd1, 14'd0, 40, 1'b0);
        run_phase(14'd3, 14'd5, 14'd7, 150, 1'b0);
        run_phase(14'd1, 14'h3FFF, 14'h3FFF, 150, 1'b1);
        run_phase(14'd2048, 14'd4096, 14'd8192, 60, 1'b0);

        // Long receiver stall in the middle of a busy phase.
        program_format(14'd5, 14'd6, 14'd12);
        no_gaps <= 1'b0;
        mark = pairs_accepted;
        queue_pairs(400);
        while (pairs_accepted < mark + 40) @(posedge aclk);
        hold_arm <= 1'b1;
        wait_for_drain();

        repeat (6)
            run_phase(14'($urandom_range(1, 6)), 14'($urandom_range(2, 9)),
                      14'($urandom_range(0, 16383)), 60, $urandom_range(0, 3) == 0);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d YUY2 pairs, checked %0d plane writes, %0d formats, %0d reg writes,",
                 pairs_accepted, writes_checked, formats_run, reg_writes);
        $display("with saturated sizes, zero stride, address wrap and a long output stall.");
        if (error_count == 0) begin
            $display("** yuy2_to_nv12_converter: PASSED **");
        end else begin
            $display("** yuy2_to_nv12_converter: FAILED **");
        end
        $finish;
    end

endmodule
